>>> rtl/sitd_pkg.sv
// Package for the signed integer to decimal ASCII unit.
// Holds the sequencer state type and the character and digit constants.
// No dependencies.
package sitd_pkg;

  localparam int CODE_W  = 7;
  localparam int DIGIT_W = 4;

  localparam logic [CODE_W-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CODE_W-1:0] CHAR_MINUS = 7'd45;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_DIGITS
  } sitd_state_t;

endpackage

>>> rtl/sitd_if.sv
// Channel interfaces for the signed integer to decimal ASCII unit.
// The input channel carries one signed integer per word, the output channel one character.
// Depends on sitd_pkg.
interface sitd_in_if #(
  parameter int VALUE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitd_out_if;
  logic                             valid;
  logic                             ready;
  logic [sitd_pkg::CODE_W-1:0]      char_code;
  logic                             last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

>>> rtl/signed_int_to_decimal_ascii_unit.sv
// Top level of the signed integer to decimal ASCII unit: sequencer, digit store, output register.
// Depends on sitd_pkg, sitd_if and sitd_div10.
//
//   channel  | direction | word contents
//   in_ch    | sink      | value (signed, VALUE_BITS bits)
//   out_ch   | source    | char_code (7 bits), last_char (1 bit)
//
// Sequence: take the integer, divide out its digits into the store, send a minus if it is negative,
// then send the digits from the most significant. The shared divide-by-ten unit yields one digit
// per cycle, and the output register sends one character per cycle unless the output stalls.
// Reset is synchronous and active low; it returns the sequencer to idle with no word pending.
// A stall holds the sign and digit states; the next integer is taken as the last character waits.
module signed_int_to_decimal_ascii_unit #(
  parameter int VALUE_BITS = 16,
  parameter int MAX_DIGITS = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  sitd_in_if.sink           in_ch,
  sitd_out_if.source        out_ch
);
  import sitd_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = $clog2(MAX_DIGITS);

  sitd_state_t            state_r, state_nxt;
  logic [VALUE_BITS-1:0]  mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [DIGIT_W-1:0]     store_r [MAX_DIGITS];
  logic                   out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]      out_code_r, out_code_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [VALUE_BITS-1:0]  quot;
  logic [DIGIT_W-1:0]     rem;
  logic                   store_we;
  logic                   out_free;
  logic                   out_load;
  logic [CNT_W-1:0]       cnt_inc;

  sitd_div10 #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div10 (
    .dividend  (mag_r),
    .quotient  (quot),
    .remainder (rem)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign cnt_inc  = cnt_r + CNT_W'(1);

  always_comb begin
    state_nxt    = state_r;
    mag_nxt      = mag_r;
    neg_nxt      = neg_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    store_we     = 1'b0;
    out_load     = 1'b0;
    out_code_nxt = out_code_r;
    out_last_nxt = out_last_r;
    in_ch.ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          neg_nxt   = in_ch.value[VALUE_BITS-1];
          mag_nxt   = in_ch.value[VALUE_BITS-1] ? (~in_ch.value + VALUE_BITS'(1))
                                                : in_ch.value;
          cnt_nxt   = '0;
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        store_we = 1'b1;
        mag_nxt  = quot;
        cnt_nxt  = cnt_inc;
        if (quot == '0 || cnt_inc == CNT_W'(MAX_DIGITS)) begin
          idx_nxt   = cnt_r[IDX_W-1:0];
          state_nxt = neg_r ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_code_nxt = CHAR_MINUS;
          out_last_nxt = 1'b0;
          state_nxt    = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_code_nxt = CHAR_ZERO + CODE_W'(store_r[idx_r]);
          out_last_nxt = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mag_r       <= '0;
      neg_r       <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mag_r       <= mag_nxt;
      neg_r       <= neg_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[cnt_r[IDX_W-1:0]] <= rem;
    end
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.char_code = out_code_r;
  assign out_ch.last_char = out_last_r;

endmodule

>>> rtl/sitd_div10.sv
// Shared divide-by-ten unit: quotient by reciprocal multiplication, remainder from the low bits.
// One multiplier followed by a 4-bit correction; used once per digit by the sequencer.
// Depends on sitd_pkg.
module sitd_div10 #(
  parameter int VALUE_BITS = 16
) (
  input  logic [VALUE_BITS-1:0]        dividend,
  output logic [VALUE_BITS-1:0]        quotient,
  output logic [sitd_pkg::DIGIT_W-1:0] remainder
);
  import sitd_pkg::*;

  localparam int SHIFT  = VALUE_BITS + 4;
  localparam int PROD_W = 2 * VALUE_BITS + 1;
  localparam int QHI_W  = PROD_W - SHIFT;
  localparam logic [VALUE_BITS:0] RECIP =
    (VALUE_BITS+1)'(((64'd1 << SHIFT) + 64'd9) / 64'd10);

  logic [PROD_W-1:0]  product;
  logic [DIGIT_W-1:0] ten_q_low;

  assign product   = PROD_W'(dividend) * PROD_W'(RECIP);
  assign quotient  = VALUE_BITS'(product[PROD_W-1 -: QHI_W]);
  // Only the low four bits of ten times the quotient matter, since the remainder is below ten.
  assign ten_q_low = {quotient[0], 3'b000} + {quotient[2:0], 1'b0};
  assign remainder = dividend[DIGIT_W-1:0] - ten_q_low;

endmodule

>>> rtl/sitd_checker.sv
// Port-level checker for the signed integer to decimal ASCII unit, with its bind statement.
// Watches the input and output channels of the top level over time.
// Depends on sitd_pkg and signed_int_to_decimal_ascii_unit.
module sitd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sitd_pkg::CODE_W-1:0] out_char_code,
  input logic                        out_last_char
);
  import sitd_pkg::*;

  logic out_is_digit;

  assign out_is_digit = (out_char_code >= CHAR_ZERO) && (out_char_code <= CHAR_ZERO + 7'd9);

  // A stalled word keeps its character.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_code) && $stable(out_last_char))
    else $error("stalled output word changed");

  a_out_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_is_digit || out_char_code == CHAR_MINUS)
    else $error("output character is neither a digit nor a minus sign");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_code == CHAR_MINUS |-> !out_last_char)
    else $error("minus sign marked as final character");

  // The unit works on one integer at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an accepted word");

endmodule

bind signed_int_to_decimal_ascii_unit sitd_checker u_sitd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_char_code (out_ch.char_code),
  .out_last_char (out_ch.last_char)
);

>>> dv/tb_top.sv
// Testbench for signed_int_to_decimal_ascii_unit: drives signed integers and checks each
// returned character against a given text or a behavioral predictor, with random idling.
// Depends on sitd_pkg, sitd_if and the unit's RTL.
module tb_top;
  import sitd_pkg::*;

  localparam int VALUE_BITS        = 16;
  localparam int MAX_DIGITS        = 5;
  localparam int RADIX             = 10;
  localparam int RANDOM_VALUES     = 280;
  localparam int LONG_STALL_CYCLES = 120;
  localparam int DRAIN_CYCLES      = 30;
  localparam int MAX_PRINTED       = 40;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } char_word_t;

  typedef struct {
    logic signed [VALUE_BITS-1:0] value;
    string                        text;
  } text_row_t;

  logic clk;
  logic rst_n;
  logic no_idle;
  logic long_stall_go;
  logic out_held;
  int   error_count;

  char_word_t expected_chars[$];

  sitd_in_if #(.VALUE_BITS(VALUE_BITS)) in_if ();
  sitd_out_if out_if ();

  signed_int_to_decimal_ascii_unit #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #8000000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    error_count++;
  endtask

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 8);
  endfunction

  // Expected decimal text of one integer, pushed character by character.
  function automatic void predict_text(input logic [VALUE_BITS-1:0] raw);
    logic [VALUE_BITS:0]  magnitude;
    logic [DIGIT_W-1:0]   digits [MAX_DIGITS];
    int                   n;
    char_word_t           ch;
    n = 0;
    magnitude = raw[VALUE_BITS-1] ? ({1'b1, {VALUE_BITS{1'b0}}} - {1'b0, raw}) : {1'b0, raw};
    if (magnitude == 0) begin
      ch.code = CHAR_ZERO;
      ch.last = 1'b1;
      expected_chars.push_back(ch);
      return;
    end
    while (magnitude != 0 && n < MAX_DIGITS) begin
      digits[n] = DIGIT_W'(magnitude % RADIX);
      magnitude = magnitude / RADIX;
      n++;
    end
    if (raw[VALUE_BITS-1]) begin
      ch.code = CHAR_MINUS;
      ch.last = 1'b0;
      expected_chars.push_back(ch);
    end
    for (int i = n - 1; i >= 0; i--) begin
      ch.code = CHAR_ZERO + CODE_W'(digits[i]);
      ch.last = (i == 0);
      expected_chars.push_back(ch);
    end
  endfunction

  function automatic void expect_text(input string text);
    char_word_t ch;
    for (int i = 0; i < text.len(); i++) begin
      ch.code = CODE_W'(text[i]);
      ch.last = (i == text.len() - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] random_value();
    int unsigned tens [5];
    int          pick;
    int          mag;
    tens = '{1, 10, 100, 1000, 10000};
    case ($urandom_range(0, 5))
      0: begin
        return VALUE_BITS'($urandom_range(0, 198)) - VALUE_BITS'(99);
      end
      1: begin
        pick = $urandom_range(0, 4);
        mag = tens[pick] - $urandom_range(0, 1);
        return $urandom_range(0, 1) ? VALUE_BITS'(-mag) : VALUE_BITS'(mag);
      end
      2: begin
        return $urandom_range(0, 1) ? VALUE_BITS'(32767 - $urandom_range(0, 20))
                                    : VALUE_BITS'(-32768 + $urandom_range(0, 20));
      end
      default: begin
        return VALUE_BITS'($urandom);
      end
    endcase
  endfunction

  task automatic check_char(input logic [CODE_W-1:0] code, input logic last);
    char_word_t want;
    if (expected_chars.size() == 0) begin
      report_mismatch($sformatf("unexpected character %0d last=%0b", code, last));
      return;
    end
    want = expected_chars.pop_front();
    if (code !== want.code) begin
      report_mismatch($sformatf("char_code %0d, expected %0d", code, want.code));
    end
    if (last !== want.last) begin
      report_mismatch($sformatf("last_char %0b, expected %0b", last, want.last));
    end
  endtask

  // An empty text means the row is checked against the predictor.
  task automatic send_value(input logic signed [VALUE_BITS-1:0] v, input string text);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    do @(posedge clk); while (!in_if.ready);
    if (text.len() != 0) begin
      expect_text(text);
    end else begin
      predict_text(v);
    end
  endtask

  task automatic wait_all_chars();
    in_if.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  initial begin : long_stall
    out_held <= 1'b0;
    wait (long_stall_go);
    @(posedge clk);
    out_held <= 1'b1;
    repeat (LONG_STALL_CYCLES) @(posedge clk);
    out_held <= 1'b0;
  end

  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        check_char(out_if.char_code, out_if.last_char);
        stall_left = draw_wait();
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_if.ready <= rst_n && stall_left == 0 && !out_held;
    end
  end

  initial begin : sender
    text_row_t rows [19];
    rows = '{
      '{16'sd0,       "0"},
      '{16'sd1,       "1"},
      '{-16'sd1,      "-1"},
      '{16'sd9,       "9"},
      '{16'sd10,      "10"},
      '{-16'sd10,     "-10"},
      '{16'sd32767,   "32767"},
      '{-16'sd32768,  "-32768"},
      '{-16'sd32767,  "-32767"},
      '{16'sd99,      ""},
      '{16'sd100,     ""},
      '{16'sd9999,    ""},
      '{16'sd10000,   ""},
      '{-16'sd9999,   ""},
      '{-16'sd10000,  ""},
      '{16'sh5555,    ""},
      '{16'shAAAA,    ""},
      '{16'sd12345,   ""},
      '{-16'sd12345,  ""}
    };
    error_count = 0;
    rst_n <= 1'b0;
    no_idle <= 1'b0;
    long_stall_go <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.value <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      send_value(rows[i].value, rows[i].text);
    end
    wait_all_chars();

    for (int i = 0; i < RANDOM_VALUES; i++) begin
      if (i == 40) begin
        long_stall_go <= 1'b1;
      end
      if (i == 140) begin
        wait_all_chars();
      end
      if (i == 170) begin
        no_idle <= 1'b1;
      end
      if (i == 220) begin
        no_idle <= 1'b0;
      end
      send_value(random_value(), "");
    end
    wait_all_chars();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
